// File: src/mus_to_midi_event_translator_top_defines.svh
// Assertion macros shared by the translator checker.
`ifndef MUS_TO_MIDI_EVENT_TRANSLATOR_TOP_DEFINES_SVH
`define MUS_TO_MIDI_EVENT_TRANSLATOR_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define MMET_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define MMET_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define MMET_AST_NXT_ANY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mmet_pkg.sv
// Types, codes and lookup functions of the MUS to MIDI event translator.
package mmet_pkg;

    localparam int unsigned CHANNELS = 16;
    localparam int unsigned CH_W     = 4;

    // Input commands
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_BYTE      = 2'd0;
    localparam t_cmd CMD_REWIND    = 2'd1;
    localparam t_cmd CMD_VEL_RESET = 2'd2;

    // Parser phases
    typedef logic [2:0] t_phase;
    localparam t_phase PH_EVENT = 3'd0;
    localparam t_phase PH_FIRST = 3'd1;
    localparam t_phase PH_VELO  = 3'd2;
    localparam t_phase PH_PROG  = 3'd3;
    localparam t_phase PH_CVAL  = 3'd4;
    localparam t_phase PH_DELAY = 3'd5;

    // MUS event types (bits 6:4 of the event byte)
    localparam logic [2:0] TY_NOTE_OFF  = 3'd0;
    localparam logic [2:0] TY_NOTE_ON   = 3'd1;
    localparam logic [2:0] TY_BEND      = 3'd2;
    localparam logic [2:0] TY_SYSTEM    = 3'd3;
    localparam logic [2:0] TY_CTRL      = 3'd4;
    localparam logic [2:0] TY_SCORE_END = 3'd6;

    // MIDI status nibbles
    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_CTRL     = 4'hB;
    localparam logic [3:0] ST_PROG     = 4'hC;
    localparam logic [3:0] ST_BEND     = 4'hE;

    // Result kinds
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_END   = 1'b1;

    localparam logic [7:0] VEL_DEFAULT  = 8'd100;
    localparam logic [7:0] NOTE_OFF_VEL = 8'd64;
    localparam logic [7:0] SYS_MONO     = 8'd12;
    localparam logic [3:0] MUS_PERC_CH  = 4'd15;
    localparam logic [3:0] MIDI_PERC_CH = 4'd9;
    localparam logic [3:0] CH_SHIFT_LO  = 4'd9;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] byte_value;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [31:0] delta_time;
        logic [7:0]  status_byte;
        logic [7:0]  data1;
        logic [7:0]  data2;
    } t_result;

    // Result request from the parser to the output stage
    typedef struct packed {
        logic    valid;
        t_result data;
    } t_res_req;

    // MUS controller number to MIDI controller number
    function automatic logic [7:0] map_ctl(input logic [7:0] t);
        logic [7:0] r;
        unique case (t)
            8'd2:    r = 8'd1;
            8'd3:    r = 8'd7;
            8'd4:    r = 8'd10;
            8'd5:    r = 8'd11;
            8'd6:    r = 8'd91;
            8'd7:    r = 8'd93;
            8'd8:    r = 8'd64;
            8'd9:    r = 8'd67;
            8'd10:   r = 8'd120;
            8'd11:   r = 8'd123;
            8'd12:   r = 8'd126;
            8'd13:   r = 8'd127;
            8'd14:   r = 8'd121;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // MUS channel to MIDI channel: percussion moves to 9, 9..14 shift up
    function automatic logic [CH_W-1:0] map_channel(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] r;
        if (c == MUS_PERC_CH) begin
            r = MIDI_PERC_CH;
        end else if (c >= CH_SHIFT_LO) begin
            r = c + 4'd1;
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

// File: src/mmet_if.sv
// Request channels of the translator: input bytes, result events, configuration.
interface mmet_in_if import mmet_pkg::*;;
    logic       valid;
    logic       ready;
    t_cmd       cmd;
    logic [7:0] byte_value;

    modport source (output valid, output cmd, output byte_value, input ready);
    modport sink (input valid, input cmd, input byte_value, output ready);
endinterface

interface mmet_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] delta_time;
    logic [7:0]  status_byte;
    logic [7:0]  data1;
    logic [7:0]  data2;

    modport source (output valid, output kind, output delta_time, output status_byte,
                    output data1, output data2, input ready);
    modport sink (input valid, input kind, input delta_time, input status_byte,
                  input data1, input data2, output ready);
endinterface

interface mmet_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] mono_channel_count;

    modport source (output valid, output mono_channel_count, input ready);
    modport sink (input valid, input mono_channel_count, output ready);
endinterface

// File: src/mus_to_midi_event_translator_top.sv
// Top level of the MUS to MIDI event translator.
//
// i_in takes one request per cycle while i_in.ready is high: cmd selects a
// score byte, a parser rewind or a reset of the per-channel note-on velocities
// to 100. Each score byte yields at most one MIDI event on o_out, carrying the
// delay read before it; the score-end marker yields an end item only when a
// delay is pending. i_cfg writes the mono channel count and is always ready.
//
// A request accepted into the input register passes through the parser into
// the output register. Throughput: one request per cycle while i_in.ready is
// high, limited by the single parser stage between the two registers.
// A two-entry output (register plus skid) lets a new request enter while a
// result still waits; when o_out stalls long enough to fill both entries,
// i_in.ready drops and the request in the input register holds.
// Synchronous reset clears the parser, empties all stages, sets every
// channel velocity to 100 and the mono channel count to zero.
module mus_to_midi_event_translator_top import mmet_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mmet_in_if.sink    i_in,
    mmet_out_if.source o_out,
    mmet_cfg_if.sink   i_cfg
);

    logic [3:0] r_mono;
    t_item      in_item;
    t_res_req   res;
    logic       hold;
    logic       out_valid;
    t_result    out_data;

    // Hold the mono channel count
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono <= 4'd0;
        end else if (i_cfg.valid) begin
            r_mono <= i_cfg.mono_channel_count;
        end
    end

    assign in_item.cmd        = i_in.cmd;
    assign in_item.byte_value = i_in.byte_value;

    mmet_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_item  (in_item),
        .o_in_ready (i_in.ready),
        .i_mono_cnt (r_mono),
        .i_hold     (hold),
        .o_res      (res)
    );

    mmet_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_hold  (hold),
        .o_valid (out_valid),
        .o_data  (out_data),
        .i_ready (o_out.ready)
    );

    assign o_out.valid       = out_valid;
    assign o_out.kind        = out_data.kind;
    assign o_out.delta_time  = out_data.delta_time;
    assign o_out.status_byte = out_data.status_byte;
    assign o_out.data1       = out_data.data1;
    assign o_out.data2       = out_data.data2;

endmodule

// File: src/mmet_parser.sv
// Input register and single-pass MUS parser with per-channel velocity store.
module mmet_parser import mmet_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_item      i_in_item,
    output logic       o_in_ready,
    input  logic [3:0] i_mono_cnt,
    input  logic       i_hold,
    output t_res_req   o_res
);

    logic            r_in_valid;
    t_item           r_in_item;
    t_phase          r_phase, n_phase;
    logic [7:0]      r_event, n_event;
    logic [7:0]      r_first, n_first;
    logic [31:0]     r_delay, n_delay;
    logic            r_done, n_done;
    logic [7:0]      r_vel [CHANNELS];
    logic [7:0]      n_vel [CHANNELS];

    logic            advance;
    logic [CH_W-1:0] ch;
    logic [2:0]      ty;
    logic [7:0]      b;
    logic            do_emit, do_end;
    logic [3:0]      st_nib;
    logic [7:0]      d1, d2;

    assign advance    = r_in_valid & ~i_hold;
    assign o_in_ready = ~r_in_valid | ~i_hold;

    // Capture the next request whenever the stage frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    assign ch = map_channel(r_event[3:0]);
    assign ty = r_event[6:4];
    assign b  = r_in_item.byte_value;

    // Decode one request against the parser state
    always_comb begin
        n_phase = r_phase;
        n_event = r_event;
        n_first = r_first;
        n_delay = r_delay;
        n_done  = r_done;
        n_vel   = r_vel;
        do_emit = 1'b0;
        do_end  = 1'b0;
        st_nib  = ST_NOTE_OFF;
        d1      = 8'd0;
        d2      = 8'd0;
        o_res.valid            = 1'b0;
        o_res.data.kind        = KIND_EVENT;
        o_res.data.delta_time  = r_delay;
        o_res.data.status_byte = 8'd0;
        o_res.data.data1       = 8'd0;
        o_res.data.data2       = 8'd0;

        unique case (r_in_item.cmd)
            CMD_REWIND: begin
                n_phase = PH_EVENT;
                n_event = 8'd0;
                n_first = 8'd0;
                n_delay = 32'd0;
                n_done  = 1'b0;
            end
            CMD_VEL_RESET: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    n_vel[i] = VEL_DEFAULT;
                end
            end
            CMD_BYTE: begin
                if (!r_done) begin
                    unique case (r_phase)
                        PH_FIRST: begin
                            n_first = b;
                            unique case (ty)
                                TY_NOTE_OFF: begin
                                    do_emit = 1'b1;
                                    st_nib  = ST_NOTE_OFF;
                                    d1      = b;
                                    d2      = NOTE_OFF_VEL;
                                end
                                TY_NOTE_ON: begin
                                    if (b[7]) begin
                                        n_phase = PH_VELO;
                                    end else begin
                                        do_emit = 1'b1;
                                        st_nib  = ST_NOTE_ON;
                                        d1      = {1'b0, b[6:0]};
                                        d2      = r_vel[ch];
                                    end
                                end
                                TY_BEND: begin
                                    do_emit = 1'b1;
                                    st_nib  = ST_BEND;
                                    d1      = {1'b0, b[0], 6'd0};
                                    d2      = {1'b0, b[7:1]};
                                end
                                TY_SYSTEM: begin
                                    do_emit = 1'b1;
                                    st_nib  = ST_CTRL;
                                    d1      = map_ctl(b);
                                    d2      = (b == SYS_MONO) ? {4'd0, i_mono_cnt} : 8'd0;
                                end
                                TY_CTRL: begin
                                    n_phase = (b == 8'd0) ? PH_PROG : PH_CVAL;
                                end
                                default: begin
                                    do_end = 1'b1;
                                end
                            endcase
                        end
                        PH_VELO: begin
                            n_vel[ch] = b;
                            do_emit   = 1'b1;
                            st_nib    = ST_NOTE_ON;
                            d1        = {1'b0, r_first[6:0]};
                            d2        = b;
                        end
                        PH_PROG: begin
                            do_emit = 1'b1;
                            st_nib  = ST_PROG;
                            d1      = b;
                        end
                        PH_CVAL: begin
                            do_emit = 1'b1;
                            st_nib  = ST_CTRL;
                            d1      = map_ctl(r_first);
                            d2      = b;
                        end
                        PH_DELAY: begin
                            n_delay = {r_delay[24:0], b[6:0]};
                            if (!b[7]) begin
                                n_phase = PH_EVENT;
                            end
                        end
                        default: begin
                            n_event = b;
                            if (b[6:4] == TY_SCORE_END) begin
                                do_end = 1'b1;
                            end else begin
                                n_phase = PH_FIRST;
                            end
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        // Emit a channel event, then read a delay or wait for the next event
        if (do_emit) begin
            o_res.valid            = advance;
            o_res.data.status_byte = {st_nib, ch};
            o_res.data.data1       = d1;
            o_res.data.data2       = d2;
            n_delay                = 32'd0;
            n_phase                = r_event[7] ? PH_DELAY : PH_EVENT;
        end

        // Close the score; report only a pending delay
        if (do_end) begin
            o_res.valid     = advance & (r_delay != 32'd0);
            o_res.data.kind = KIND_END;
            n_delay         = 32'd0;
            n_done          = 1'b1;
            n_phase         = PH_EVENT;
        end
    end

    // Advance the parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_EVENT;
            r_event <= 8'd0;
            r_first <= 8'd0;
            r_delay <= 32'd0;
            r_done  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_vel[i] <= VEL_DEFAULT;
            end
        end else if (advance) begin
            r_phase <= n_phase;
            r_event <= n_event;
            r_first <= n_first;
            r_delay <= n_delay;
            r_done  <= n_done;
            r_vel   <= n_vel;
        end
    end

endmodule

// File: src/mmet_out_skid.sv
// Output register with a skid entry so the parser never waits on a combinational ready.
module mmet_out_skid import mmet_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_res_req i_res,
    output logic     o_hold,
    output logic     o_valid,
    output t_result  o_data,
    input  logic     i_ready
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    out_free;

    assign out_free = ~r_out_valid | i_ready;
    assign o_hold   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // Refill the output from the skid entry first, park a result when stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_res.valid;
            end
        end else if (i_res.valid) begin
            r_skid_valid <= 1'b1;
        end
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res.data;
        end
        if (!out_free && i_res.valid) begin
            r_skid <= i_res.data;
        end
    end

endmodule

// File: src/mmet_checker.sv
// Port-level checker for the translator and its bind to the top level.
`include "mus_to_midi_event_translator_top_defines.svh"

module mmet_checker import mmet_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_cfg_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_kind,
    input logic [31:0] i_out_delta_time,
    input logic [7:0]  i_out_status_byte,
    input logic [7:0]  i_out_data1,
    input logic [7:0]  i_out_data2
);

    // Reset empties the pipeline and opens the input
    `MMET_AST_NXT_ANY(a_reset_empty, !i_rst_n, !i_out_valid && i_in_ready, "not empty after reset")

    // A stalled result holds
    `MMET_AST_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_delta_time) && $stable(i_out_status_byte) && $stable(i_out_data1) && $stable(i_out_data2) && $stable(i_out_kind), "stalled result changed")

    // End items carry only a nonzero delay
    `MMET_AST_IMP(a_end_item, i_out_valid && i_out_kind == KIND_END, i_out_delta_time != 32'd0 && i_out_status_byte == 8'd0 && i_out_data1 == 8'd0 && i_out_data2 == 8'd0, "bad end item")

    // Channel events use only the translated status types
    `MMET_AST_IMP(a_status, i_out_valid && i_out_kind == KIND_EVENT, i_out_status_byte[7] && i_out_status_byte[6:4] != 3'd2 && i_out_status_byte[6:4] != 3'd5 && i_out_status_byte[6:4] != 3'd7, "bad status type")

    // Configuration writes are never refused
    `MMET_AST_IMP(a_cfg_ready, 1'b1, i_cfg_ready, "config port not ready")

endmodule

bind mus_to_midi_event_translator_top mmet_checker u_mmet_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_in.ready),
    .i_cfg_ready       (i_cfg.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_kind        (o_out.kind),
    .i_out_delta_time  (o_out.delta_time),
    .i_out_status_byte (o_out.status_byte),
    .i_out_data1       (o_out.data1),
    .i_out_data2       (o_out.data2)
);
